>>> hw/rtl/scaled_rounded_signed_divide_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled rounded signed divider
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALED_ROUNDED_SIGNED_DIVIDE_TOP_ASSERT_SVH
`define SCALED_ROUNDED_SIGNED_DIVIDE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SRSD_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srsd assertion failed");
// next-cycle implication
`define SRSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srsd assertion failed");
`else
`define SRSD_ASSERT(label, ante, cons)
`define SRSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg
// Types and constants for the scaled rounded signed divider.
// ----------------------------------------------------------------------------
package srsd_pkg;

	localparam int MAG_TOP_BIT = 63;
	localparam int QUOT_BITS   = 31;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIV_ZERO  = 2'd1,
		ST_SCALE_OVF = 2'd2,
		ST_QUOT_OVF  = 2'd3
	} status_t;

endpackage

>>> hw/rtl/scaled_rounded_signed_divide_top.sv
// ----------------------------------------------------------------------------
// scaled_rounded_signed_divide_top
// Fully pipelined rounded divide of a power-of-two scaled 64-bit dividend by
// a 32-bit divisor, with error status.
// ----------------------------------------------------------------------------
// One beat enters per cycle while in_stall is low. Four front stages take the
// magnitudes, scale, add the rounding term and check the quotient range;
// the 31 quotient bits then come from a restoring divider with one bit per
// stage, and a last stage applies the sign. Every stage holds its beat under
// stall and empty stages keep filling, so stall reaches the input only when
// the whole pipeline is full. Errors force the quotient to zero: divide by
// zero has priority over scaling overflow, which has priority over
// quotient overflow.
`include "scaled_rounded_signed_divide_top_assert.svh"

module scaled_rounded_signed_divide_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [63:0]      dividend,
	input  logic signed [6:0]       shift_amount,
	input  logic signed [31:0]      divisor,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      quotient,
	output srsd_pkg::status_t       status
);
	import srsd_pkg::*;

	// stage 1: magnitudes
	logic        vld_s1, rdy_s1;
	logic [63:0] mag_s1;
	logic [31:0] dmag_s1;
	logic [6:0]  sh_s1;
	logic        neg_s1;
	status_t     st_s1;

	// stage 2: scaled magnitude
	logic        vld_s2, rdy_s2;
	logic [63:0] mag_s2;
	logic [31:0] dmag_s2;
	logic        neg_s2;
	status_t     st_s2;

	// stage 3: rounded magnitude
	logic        vld_s3, rdy_s3;
	logic [63:0] sum_s3;
	logic [31:0] dmag_s3;
	logic        neg_s3;
	status_t     st_s3;

	// index 0 is stage 4 (range check), index k+1 follows quotient bit step k
	logic                 vld_s [0:QUOT_BITS];
	logic                 rdy_s [0:QUOT_BITS];
	logic [31:0]          rem_s [0:QUOT_BITS];
	logic [QUOT_BITS-1:0] low_s [0:QUOT_BITS];
	logic [QUOT_BITS-1:0] q_s   [0:QUOT_BITS];
	logic [31:0]          dmag_s[0:QUOT_BITS];
	logic                 neg_s [0:QUOT_BITS];
	status_t              st_s  [0:QUOT_BITS];

	// last stage: signed result
	logic        vld_s6, rdy_s6;
	logic [31:0] quot_s6;
	status_t     st_s6;

	// stage 1 inputs
	logic [63:0] mag_in;
	logic [31:0] dmag_in;

	// stage 2 shifter
	logic [5:0]  lamt;
	logic [6:0]  ramt;
	logic [63:0] mag_shl, mag_shr;
	logic        scale_ovf;

	logic        in_beat;

	// ready chain
	assign rdy_s6             = !vld_s6 || !out_stall;
	assign rdy_s[QUOT_BITS]   = !vld_s[QUOT_BITS] || rdy_s6;
	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_rdy
		assign rdy_s[k] = !vld_s[k] || rdy_s[k+1];
	end
	assign rdy_s3   = !vld_s3 || rdy_s[0];
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1
	assign mag_in  = dividend[63] ? (~dividend + 64'd1) : dividend;
	assign dmag_in = divisor[31] ? (~divisor + 32'd1) : divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mag_s1  <= mag_in;
			dmag_s1 <= dmag_in;
			sh_s1   <= shift_amount;
			neg_s1  <= dividend[63] ^ divisor[31];
			st_s1   <= (divisor == 32'd0) ? ST_DIV_ZERO : ST_OK;
		end
	end

	// stage 2
	assign lamt      = sh_s1[5:0];
	assign ramt      = ~sh_s1 + 7'd1;
	assign scale_ovf = (mag_s1 >> (6'(MAG_TOP_BIT) - lamt)) != 64'd0;
	assign mag_shl   = mag_s1 << lamt;
	assign mag_shr   = ramt[6] ? 64'd0 : (mag_s1 >> ramt[5:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			dmag_s2 <= dmag_s1;
			neg_s2  <= neg_s1;
			if (sh_s1[6]) begin
				mag_s2 <= mag_shr;
				st_s2  <= st_s1;
			end else if (sh_s1 != 7'd0) begin
				mag_s2 <= mag_shl;
				st_s2  <= (st_s1 == ST_OK && scale_ovf) ? ST_SCALE_OVF : st_s1;
			end else begin
				mag_s2 <= mag_s1;
				st_s2  <= st_s1;
			end
		end
	end

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			sum_s3  <= mag_s2 + {33'd0, dmag_s2[31:1]};
			dmag_s3 <= dmag_s2;
			neg_s3  <= neg_s2;
			st_s3   <= st_s2;
		end
	end

	// stage 4: range check, split into partial remainder and pending bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy_s[0]) begin
			vld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s[0] && vld_s3) begin
			rem_s[0]  <= sum_s3[62:31];
			low_s[0]  <= sum_s3[30:0];
			q_s[0]    <= '0;
			dmag_s[0] <= dmag_s3;
			neg_s[0]  <= neg_s3;
			if (st_s3 == ST_OK && sum_s3 >= {1'b0, dmag_s3, 31'd0}) begin
				st_s[0] <= ST_QUOT_OVF;
			end else begin
				st_s[0] <= st_s3;
			end
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
		logic [32:0] trial;
		logic [33:0] diff;
		logic        ge;

		assign trial = {rem_s[k], low_s[k][QUOT_BITS-1]};
		assign diff  = {1'b0, trial} - {2'b00, dmag_s[k]};
		assign ge    = !diff[33];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (rdy_s[k+1]) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k+1] && vld_s[k]) begin
				rem_s[k+1]  <= ge ? diff[31:0] : trial[31:0];
				low_s[k+1]  <= {low_s[k][QUOT_BITS-2:0], 1'b0};
				q_s[k+1]    <= {q_s[k][QUOT_BITS-2:0], ge};
				dmag_s[k+1] <= dmag_s[k];
				neg_s[k+1]  <= neg_s[k];
				st_s[k+1]   <= st_s[k];
			end
		end
	end

	// last stage: sign and error masking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= vld_s[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s[QUOT_BITS]) begin
			st_s6 <= st_s[QUOT_BITS];
			if (st_s[QUOT_BITS] != ST_OK) begin
				quot_s6 <= 32'd0;
			end else if (neg_s[QUOT_BITS]) begin
				quot_s6 <= ~{1'b0, q_s[QUOT_BITS]} + 32'd1;
			end else begin
				quot_s6 <= {1'b0, q_s[QUOT_BITS]};
			end
		end
	end

	assign out_valid = vld_s6;
	assign quotient  = quot_s6;
	assign status    = st_s6;

	assign in_beat = in_valid && !in_stall;

	`SRSD_ASSERT(a_err_zero_quot, out_valid && status != ST_OK, quotient == 32'd0)
	`SRSD_ASSERT(a_quot_in_range, out_valid && status == ST_OK, quotient != 32'h8000_0000)
	`SRSD_ASSERT(a_empty_out_no_stall, !out_valid, !in_stall)
	`SRSD_ASSERT_NEXT(a_div_zero_flag, in_beat && divisor == 32'd0, vld_s1 && st_s1 == ST_DIV_ZERO)

endmodule

>>> tb/scaled_rounded_signed_divide_top_tb.sv
// ----------------------------------------------------------------------------
// scaled_rounded_signed_divide_top_tb
// Drives dividend, shift and divisor beats into the pipelined divider and
// checks each quotient and status against an in-bench model of the scaled,
// rounded division. A directed set covers error priority, the most negative
// operands, the shift limits and rounding. Random streams follow under
// different amounts of input idling and output stall.
// ----------------------------------------------------------------------------
module scaled_rounded_signed_divide_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srsd_pkg::*;

	localparam int RAND_ITEMS     = 405;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [31:0] quotient;
		status_t     status;
	} div_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [63:0] dividend;
	logic signed [6:0]  shift_amount;
	logic signed [31:0] divisor;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] quotient;
	status_t            status;

	div_result_t pending_results[$];
	int          mismatch_count;
	int          sender_idle_pct;
	int          receiver_stall_pct;

	scaled_rounded_signed_divide_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.dividend     (dividend),
		.shift_amount (shift_amount),
		.divisor      (divisor),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.quotient     (quotient),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic div_result_t predict_division(input logic [63:0] x,
			input logic [6:0] sh, input logic [31:0] d);
		div_result_t r;
		logic [63:0] mag;
		logic [63:0] dmag;
		logic [63:0] q;
		int          amt;
		r.quotient = '0;
		r.status   = ST_OK;
		amt = int'($signed(sh));
		if (d == '0) begin
			r.status = ST_DIV_ZERO;
			return r;
		end
		mag  = x[63] ? (64'd0 - x) : x;
		dmag = d[31] ? (64'h1_0000_0000 - {32'd0, d}) : {32'd0, d};
		if (amt > 0) begin
			if ((mag >> (MAG_TOP_BIT - amt)) != 64'd0) begin
				r.status = ST_SCALE_OVF;
				return r;
			end
			mag = mag << amt;
		end else if (amt < 0) begin
			mag = (-amt >= 64) ? 64'd0 : (mag >> (-amt));
		end
		mag = mag + (dmag >> 1);
		if (mag >= (dmag << QUOT_BITS)) begin
			r.status = ST_QUOT_OVF;
			return r;
		end
		q = mag / dmag;
		if (x[63] != d[31])
			q = 64'd0 - q;
		r.quotient = q[31:0];
		return r;
	endfunction

	function automatic logic [63:0] rand_bits(input int n);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (n <= 0)
			v = '0;
		else if (n < 64)
			v = v & ((64'd1 << n) - 64'd1);
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// one input beat, held until accepted
	task automatic send_beat(input logic [63:0] x, input logic [6:0] sh,
			input logic [31:0] d);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		dividend     <= x;
		shift_amount <= sh;
		divisor      <= d;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(predict_division(x, sh, d));
	endtask

	task automatic gen_random_item(output logic [63:0] x, output logic [6:0] sh,
			output logic [31:0] d);
		int          pick;
		int          dlen;
		int          xlen;
		int          amt;
		logic [63:0] mag;
		logic [31:0] dmag;
		pick = $urandom_range(0, 99);
		x  = {$urandom, $urandom};
		sh = 7'($urandom_range(0, 127));
		d  = $urandom;
		if (pick < 5) begin
			d = '0;
		end else if (pick < 9) begin
			x = 64'h8000_0000_0000_0000;
			sh = 7'($urandom_range(0, 99) < 50 ? $urandom_range(0, 127) - 64
					: -$urandom_range(0, 40));
		end else if (pick >= 13) begin
			dlen = $urandom_range(1, 32);
			if (dlen == 32)
				dmag = 32'h8000_0000;
			else
				dmag = 32'(rand_bits(dlen)) | (32'd1 << (dlen - 1));
			d = $urandom_range(0, 1) ? (32'd0 - dmag) : dmag;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				amt = 0;
			else if (pick < 80)
				amt = $urandom_range(0, 32) - 16;
			else
				amt = $urandom_range(0, 127) - 64;
			sh = 7'(amt);
			xlen = dlen + 31 - amt + $urandom_range(0, 22) - 20;
			if (xlen < 0)
				xlen = 0;
			if (xlen > 63)
				xlen = 63;
			mag = rand_bits(xlen);
			if (xlen > 0)
				mag = mag | (64'd1 << (xlen - 1));
			x = $urandom_range(0, 1) ? (64'd0 - mag) : mag;
		end
	endtask

	task automatic run_random_stream(input int n, input bit pause_midway);
		logic [63:0] x;
		logic [6:0]  sh;
		logic [31:0] d;
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			gen_random_item(x, sh, d);
			send_beat(x, sh, d);
		end
	endtask

	task automatic test_divide_by_zero;
		send_beat(64'h7fff_ffff_ffff_ffff, 7'sd0, 32'd0);
		send_beat(64'h8000_0000_0000_0000, 7'sd5, 32'd0);
		send_beat(64'd0, -7'sd64, 32'd0);
	endtask

	task automatic test_scaling_limits;
		send_beat(64'h8000_0000_0000_0000, 7'sd1, 32'd1);
		send_beat(64'h8000_0000_0000_0000, -7'sd63, 32'd1);
		send_beat(64'd1, 7'sd63, 32'd1);
		send_beat(64'd0, 7'sd63, 32'd1);
		send_beat(64'h3fff_ffff_ffff_ffff, 7'sd1, 32'h8000_0000);
		send_beat(64'h4000_0000_0000_0000, 7'sd1, 32'd5);
		send_beat(64'h7fff_ffff_ffff_ffff, -7'sd64, 32'd3);
		send_beat(64'd1, 7'sd30, 32'd1);
	endtask

	task automatic test_quotient_range;
		send_beat(64'h8000_0000_0000_0000, 7'sd0, 32'h8000_0000);
		send_beat(64'h7fff_ffff_ffff_ffff, -7'sd32, 32'hffff_ffff);
		send_beat(64'hffff_ffff_ffff_ffff, 7'sd31, 32'd1);
		send_beat(64'h7fff_ffff_ffff_ffff, -7'sd33, 32'd1);
		send_beat(64'h7fff_ffff_ffff_ffff, 7'sd0, 32'h7fff_ffff);
		send_beat(64'he000_0000_0000_0000, -7'sd30, 32'h8000_0000);
	endtask

	task automatic test_rounding;
		send_beat(64'd5, 7'sd0, 32'd2);
		send_beat(64'd7, 7'sd0, 32'hffff_fffe);
		send_beat(64'd3, 7'sd0, 32'd7);
		send_beat(64'd4, 7'sd0, 32'd7);
		send_beat(64'hffff_ffff_ffff_fffc, 7'sd0, 32'd7);
		// signs differ, quotient rounds to zero
		send_beat(64'h8000_0000_0000_0000, -7'sd40, 32'h7fff_ffff);
		send_beat(64'h0000_0000_7fff_ffff, 7'sd0, 32'h7fff_ffff);
	endtask

	task automatic test_stream_no_idle;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		run_random_stream(RAND_ITEMS, 1'b0);
	endtask

	task automatic test_stream_sender_idle;
		sender_idle_pct    = 52;
		receiver_stall_pct = 0;
		run_random_stream(RAND_ITEMS, 1'b1);
	endtask

	task automatic test_stream_receiver_stall;
		sender_idle_pct    = 0;
		receiver_stall_pct = 52;
		run_random_stream(RAND_ITEMS, 1'b0);
	endtask

	task automatic test_stream_both_idle;
		sender_idle_pct    = 24;
		receiver_stall_pct = 24;
		run_random_stream(RAND_ITEMS, 1'b1);
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

	always @(posedge clk) begin
		div_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", {32'd0, quotient}, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (quotient !== want.quotient)
					report_mismatch("quotient", {32'd0, quotient}, {32'd0, want.quotient});
				if (status !== want.status)
					report_mismatch("status", {62'd0, status}, {62'd0, want.status});
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		mismatch_count     = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		dividend     <= '0;
		shift_amount <= '0;
		divisor      <= '0;
		out_stall    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_divide_by_zero();
		test_scaling_limits();
		test_quotient_range();
		test_rounding();
		test_stream_no_idle();
		test_stream_sender_idle();
		test_stream_receiver_stall();
		test_stream_both_idle();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
